// ===== sv/smbu_pkg.sv =====
// Shared types, codes and constants for the sprite motion and bounds block.
// Used by sprite_motion_bounds_update and smbu_shrink_div; depends on nothing.
`timescale 1ns / 1ps

package smbu_pkg;

    // Default parameter values
    localparam int COORD_BITS_DEF = 16;
    localparam int SHRINK_DIV_DEF = 12;

    // Fixed field widths of the streams and registers
    localparam int FIELD_BITS     = 16;
    localparam int SIZE_BITS      = 12;
    localparam int FRAME_BITS     = 8;
    localparam int DELAY_BITS     = 17;
    localparam int KIND_BITS      = 2;
    localparam int EDGE_BITS      = 2;
    localparam int CFG_IDX_BITS   = 3;
    localparam int IN_TDATA_BITS  = 88;
    localparam int OUT_TDATA_BITS = 136;

    // Item kinds carried in the input tuser
    localparam logic [KIND_BITS-1:0] KIND_TICK   = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_PLACE  = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_KILL   = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;

    // Bounds rules
    localparam logic [EDGE_BITS-1:0] EDGE_STOP   = 2'd0;
    localparam logic [EDGE_BITS-1:0] EDGE_WRAP   = 2'd1;
    localparam logic [EDGE_BITS-1:0] EDGE_BOUNCE = 2'd2;
    localparam logic [EDGE_BITS-1:0] EDGE_DIE    = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOUND_LEFT   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOUND_TOP    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOUND_RIGHT  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOUND_BOTTOM = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_EDGE_MODE    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_COUNT  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_DELAY  = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ONE_SHOT     = 3'd7;

    // Register reset values
    localparam logic signed [FIELD_BITS-1:0] BOUND_RIGHT_RST  = 16'sd640;
    localparam logic signed [FIELD_BITS-1:0] BOUND_BOTTOM_RST = 16'sd480;
    localparam logic [FRAME_BITS-1:0]        FRAME_COUNT_RST  = 8'd1;

    // Configuration register set
    typedef struct packed {
        logic signed [FIELD_BITS-1:0] bound_left;
        logic signed [FIELD_BITS-1:0] bound_top;
        logic signed [FIELD_BITS-1:0] bound_right;
        logic signed [FIELD_BITS-1:0] bound_bottom;
        logic [EDGE_BITS-1:0]         edge_mode;
        logic [FRAME_BITS-1:0]        frame_count;
        logic signed [FIELD_BITS-1:0] frame_delay;
        logic                         one_shot;
    } t_cfg;

endpackage

// ===== sv/smbu_shrink_div.sv =====
// Divides a sprite size by a constant, truncating, through a reciprocal multiply.
// Depends on smbu_pkg for the size width.
`timescale 1ns / 1ps

module smbu_shrink_div
    import smbu_pkg::*;
#(
    parameter int DIV = SHRINK_DIV_DEF
) (
    input  logic [SIZE_BITS-1:0] i_size,
    output logic [SIZE_BITS-1:0] o_quot
);

    // With a shift of twice the size width the rounding error of the reciprocal
    // stays below one part in the divisor for every size, so the quotient is exact.
    localparam int SHIFT      = 2 * SIZE_BITS;
    localparam int RECIP_BITS = SHIFT + 1;
    localparam int PROD_BITS  = SIZE_BITS + RECIP_BITS;
    localparam logic [RECIP_BITS-1:0] RECIP =
        RECIP_BITS'((64'd1 << SHIFT) / DIV + 64'd1);

    logic [PROD_BITS-1:0] w_prod;

    // Multiply by the reciprocal and keep the integer part.
    assign w_prod = PROD_BITS'(i_size) * PROD_BITS'(RECIP);
    assign o_quot = w_prod[SHIFT +: SIZE_BITS];

endmodule

// ===== sv/sprite_motion_bounds_update.sv =====
// Top level of the sprite motion engine: input register, update logic, result register.
// Depends on smbu_pkg and smbu_shrink_div.
//
//   Channel   Direction  Handshake                       Contents
//   s_axis    in         i_s_axis_tvalid/o_s_axis_tready  tuser kind, tdata place fields
//   m_axis    out        o_m_axis_tvalid/i_m_axis_tready  tuser killed, tdata sprite state
//   cfg       in         i_cfg_valid/o_cfg_ready          index and data of one register
//
// One item is taken every cycle unless the input side stalls; its result is registered
// first in the input register and then in the result register.
// The input register and the result register are the only stages: one pass of
// adds, compares and saturation lies between them.
// Synchronous active-low reset restores the register defaults and clears the sprite.
// A stalled result holds the result register; the input register still takes
// one more item, and the input side stalls only when both are full.
`timescale 1ns / 1ps

module sprite_motion_bounds_update
    import smbu_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int SHRINK_DIV = SHRINK_DIV_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input stream
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // tdata: place_x, place_y, sprite_width, sprite_height, place_vx, place_vy
    input  logic [IN_TDATA_BITS-1:0]      i_s_axis_tdata,
    // tuser: kind
    input  logic [KIND_BITS-1:0]          i_s_axis_tuser,
    // Result stream
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // tdata: pos_x, pos_y, vel_x, vel_y, frame_index,
    //        hit_left, hit_top, hit_right, hit_bottom
    output logic [OUT_TDATA_BITS-1:0]     o_m_axis_tdata,
    // tuser: killed
    output logic                          o_m_axis_tuser,
    // Configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [FIELD_BITS-1:0]         i_cfg_data
);

    // Working width holds every sum of a coordinate, a size and a bound.
    localparam int W = ((COORD_BITS > FIELD_BITS) ? COORD_BITS : FIELD_BITS) + 3;
    localparam logic signed [W-1:0] SAT_HI = W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [W-1:0] SAT_LO = -SAT_HI - W'(1);

    // Saturate a working value to the coordinate range.
    function automatic logic signed [COORD_BITS-1:0] f_sat(input logic signed [W-1:0] v);
        if (v > SAT_HI) begin
            return SAT_HI[COORD_BITS-1:0];
        end else if (v < SAT_LO) begin
            return SAT_LO[COORD_BITS-1:0];
        end
        return v[COORD_BITS-1:0];
    endfunction

    // Sign-extend a coordinate to the working width.
    function automatic logic signed [W-1:0] f_ext(input logic signed [COORD_BITS-1:0] v);
        return W'(v);
    endfunction

    // Low field bits of a sign-extended coordinate.
    function automatic logic [FIELD_BITS-1:0] f_low(input logic signed [COORD_BITS-1:0] v);
        logic signed [W-1:0] t;
        t = W'(v);
        return t[FIELD_BITS-1:0];
    endfunction

    // Configuration registers
    t_cfg r_cfg;

    // Input register
    logic                         r_in_valid;
    logic [KIND_BITS-1:0]         r_in_kind;
    logic signed [FIELD_BITS-1:0] r_in_px, r_in_py, r_in_vx, r_in_vy;
    logic [SIZE_BITS-1:0]         r_in_w, r_in_h, r_in_sw, r_in_sh;
    logic [SIZE_BITS-1:0]         w_quot_w, w_quot_h;

    // Sprite state
    logic signed [COORD_BITS-1:0] r_left, r_top, r_vx, r_vy;
    logic signed [COORD_BITS-1:0] n_left, n_top, n_vx, n_vy;
    logic [SIZE_BITS-1:0]         r_size_w, r_size_h, r_shrink_w, r_shrink_h;
    logic [SIZE_BITS-1:0]         n_size_w, n_size_h, n_shrink_w, n_shrink_h;
    logic [FRAME_BITS-1:0]        r_frame, n_frame;
    logic signed [DELAY_BITS-1:0] r_delay, n_delay;
    logic                         r_dying, n_dying;
    logic                         n_killed;

    // Result register
    logic                         r_out_valid;
    logic                         r_out_killed;
    logic [OUT_TDATA_BITS-1:0]    r_out_data;
    logic [OUT_TDATA_BITS-1:0]    n_out_data;

    // Handshake
    logic w_out_load, w_adv, w_in_xfer;

    // Frame step
    logic signed [DELAY_BITS-1:0] w_dec;
    logic [FRAME_BITS:0]          w_frame_inc;
    logic [FRAME_BITS-1:0]        w_step_frame;
    logic signed [DELAY_BITS-1:0] w_step_delay;
    logic                         w_step_dying;

    // Motion
    logic signed [W-1:0] w_px, w_py, w_vx, w_vy, w_szw, w_szh;
    logic signed [W-1:0] w_bl, w_bt, w_br, w_bb;
    logic signed [W-1:0] w_nx, w_ny, w_nxw, w_nyh, w_rmw, w_bmh;
    logic signed [W-1:0] w_cx, w_cy, w_cx2, w_cy2;
    logic signed [W-1:0] w_mx, w_my, w_mvx, w_mvy;
    logic                w_die_out;

    // Result edges
    logic signed [W-1:0]          w_hl, w_ht, w_hr, w_hb;
    logic signed [COORD_BITS-1:0] w_hl_s, w_ht_s, w_hr_s, w_hb_s;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bound_left   <= '0;
            r_cfg.bound_top    <= '0;
            r_cfg.bound_right  <= BOUND_RIGHT_RST;
            r_cfg.bound_bottom <= BOUND_BOTTOM_RST;
            r_cfg.edge_mode    <= EDGE_STOP;
            r_cfg.frame_count  <= FRAME_COUNT_RST;
            r_cfg.frame_delay  <= '0;
            r_cfg.one_shot     <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BOUND_LEFT:   r_cfg.bound_left   <= i_cfg_data;
                CFG_BOUND_TOP:    r_cfg.bound_top    <= i_cfg_data;
                CFG_BOUND_RIGHT:  r_cfg.bound_right  <= i_cfg_data;
                CFG_BOUND_BOTTOM: r_cfg.bound_bottom <= i_cfg_data;
                CFG_EDGE_MODE:    r_cfg.edge_mode    <= i_cfg_data[EDGE_BITS-1:0];
                CFG_FRAME_COUNT:  r_cfg.frame_count  <= i_cfg_data[FRAME_BITS-1:0];
                CFG_FRAME_DELAY:  r_cfg.frame_delay  <= i_cfg_data;
                CFG_ONE_SHOT:     r_cfg.one_shot     <= i_cfg_data[0];
            endcase
        end
    end

    // The input register moves on whenever the result register is free or drained.
    assign w_out_load      = !r_out_valid || i_m_axis_tready;
    assign w_adv           = r_in_valid && w_out_load;
    assign o_s_axis_tready = !r_in_valid || w_out_load;
    assign w_in_xfer       = i_s_axis_tvalid && o_s_axis_tready;

    // Shrink amounts are worked out on the way into the input register.
    smbu_shrink_div #(.DIV(SHRINK_DIV)) u_shrink_w (
        .i_size (i_s_axis_tdata[43:32]),
        .o_quot (w_quot_w)
    );

    smbu_shrink_div #(.DIV(SHRINK_DIV)) u_shrink_h (
        .i_size (i_s_axis_tdata[55:44]),
        .o_quot (w_quot_h)
    );

    // Input register; the kind starts as a tick so the decode never sees an unknown.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_in_kind  <= KIND_TICK;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (w_in_xfer) begin
                r_in_kind <= i_s_axis_tuser;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in_px   <= i_s_axis_tdata[15:0];
            r_in_py   <= i_s_axis_tdata[31:16];
            r_in_w    <= i_s_axis_tdata[43:32];
            r_in_h    <= i_s_axis_tdata[55:44];
            r_in_vx   <= i_s_axis_tdata[71:56];
            r_in_vy   <= i_s_axis_tdata[87:72];
            r_in_sw   <= w_quot_w;
            r_in_sh   <= w_quot_h;
        end
    end

    // Animation step, skipped for a negative delay: count down the delay, then advance, wrap or end the pass.
    assign w_dec       = r_delay - DELAY_BITS'(1);
    assign w_frame_inc = {1'b0, r_frame} + (FRAME_BITS + 1)'(1);

    always_comb begin
        w_step_frame = r_frame;
        w_step_delay = r_delay;
        w_step_dying = r_dying;
        if (!r_cfg.frame_delay[FIELD_BITS-1]) begin
            w_step_delay = w_dec;
            if (w_dec <= DELAY_BITS'(0)) begin
                w_step_delay = DELAY_BITS'(r_cfg.frame_delay);
                w_step_frame = w_frame_inc[FRAME_BITS-1:0];
                if (w_frame_inc >= {1'b0, r_cfg.frame_count}) begin
                    if (r_cfg.one_shot) begin
                        w_step_dying = 1'b1;
                        if (w_frame_inc[FRAME_BITS]) begin
                            w_step_frame = '1;
                        end
                    end else begin
                        w_step_frame = '0;
                    end
                end
            end
        end
    end

    // Move by the velocity in the working width.
    always_comb begin
        w_px  = f_ext(r_left);
        w_py  = f_ext(r_top);
        w_vx  = f_ext(r_vx);
        w_vy  = f_ext(r_vy);
        w_szw = W'(r_size_w);
        w_szh = W'(r_size_h);
        w_bl  = W'(r_cfg.bound_left);
        w_bt  = W'(r_cfg.bound_top);
        w_br  = W'(r_cfg.bound_right);
        w_bb  = W'(r_cfg.bound_bottom);
        w_nx  = w_px + w_vx;
        w_ny  = w_py + w_vy;
        w_nxw = w_nx + w_szw;
        w_nyh = w_ny + w_szh;
        w_rmw = w_br - w_szw;
        w_bmh = w_bb - w_szh;
        // Clamp for the stop rule; the low bound wins when the area is too narrow.
        w_cx  = (w_nx > w_rmw) ? w_rmw : w_nx;
        w_cx2 = (w_cx < w_bl) ? w_bl : w_cx;
        w_cy  = (w_ny > w_bmh) ? w_bmh : w_ny;
        w_cy2 = (w_cy < w_bt) ? w_bt : w_cy;
    end

    // Bounds rule
    always_comb begin
        w_mx      = w_nx;
        w_my      = w_ny;
        w_mvx     = w_vx;
        w_mvy     = w_vy;
        w_die_out = 1'b0;
        unique case (r_cfg.edge_mode)
            EDGE_WRAP: begin
                if (w_nxw < w_bl) begin
                    w_mx = w_br;
                end else if (w_nx > w_br) begin
                    w_mx = w_bl - w_szw;
                end
                if (w_nyh < w_bt) begin
                    w_my = w_bb;
                end else if (w_ny > w_bb) begin
                    w_my = w_bt - w_szh;
                end
            end
            EDGE_BOUNCE: begin
                if (w_nx < w_bl) begin
                    w_mx  = w_bl;
                    w_mvx = -w_vx;
                end else if (w_nxw > w_br) begin
                    w_mx  = w_rmw;
                    w_mvx = -w_vx;
                end
                if (w_ny < w_bt) begin
                    w_my  = w_bt;
                    w_mvy = -w_vy;
                end else if (w_nyh > w_bb) begin
                    w_my  = w_bmh;
                    w_mvy = -w_vy;
                end
            end
            EDGE_DIE: begin
                w_die_out = (w_nxw < w_bl) || (w_nx > w_br) ||
                            (w_nyh < w_bt) || (w_ny > w_bb);
            end
            EDGE_STOP: begin
                if ((w_nx < w_bl) || (w_nx > w_rmw)) begin
                    w_mx  = w_cx2;
                    w_mvx = '0;
                    w_mvy = '0;
                end
                if ((w_ny < w_bt) || (w_ny > w_bmh)) begin
                    w_my  = w_cy2;
                    w_mvx = '0;
                    w_mvy = '0;
                end
            end
        endcase
    end

    // Next sprite state for the item in the input register.
    always_comb begin
        n_left     = r_left;
        n_top      = r_top;
        n_vx       = r_vx;
        n_vy       = r_vy;
        n_size_w   = r_size_w;
        n_size_h   = r_size_h;
        n_shrink_w = r_shrink_w;
        n_shrink_h = r_shrink_h;
        n_frame    = r_frame;
        n_delay    = r_delay;
        n_dying    = r_dying;
        n_killed   = 1'b0;
        unique case (r_in_kind)
            KIND_PLACE: begin
                n_left     = f_sat(W'(r_in_px));
                n_top      = f_sat(W'(r_in_py));
                n_vx       = f_sat(W'(r_in_vx));
                n_vy       = f_sat(W'(r_in_vy));
                n_size_w   = r_in_w;
                n_size_h   = r_in_h;
                n_shrink_w = r_in_sw;
                n_shrink_h = r_in_sh;
                n_frame    = '0;
                n_delay    = '0;
                n_dying    = 1'b0;
            end
            KIND_KILL: begin
                n_dying = 1'b1;
            end
            KIND_UNUSED: begin
                n_killed = 1'b0;
            end
            KIND_TICK: begin
                if (r_dying) begin
                    n_killed = 1'b1;
                end else begin
                    n_frame = w_step_frame;
                    n_delay = w_step_delay;
                    n_dying = w_step_dying;
                    // Leaving the area under the die rule reports kill and does not move.
                    if (w_die_out) begin
                        n_killed = 1'b1;
                    end else begin
                        n_left = f_sat(w_mx);
                        n_top  = f_sat(w_my);
                        n_vx   = f_sat(w_mvx);
                        n_vy   = f_sat(w_mvy);
                    end
                end
            end
        endcase
    end

    // Collision rectangle from the new state.
    always_comb begin
        w_hl   = f_ext(n_left) + W'(n_shrink_w);
        w_ht   = f_ext(n_top) + W'(n_shrink_h);
        w_hr   = f_ext(n_left) + W'(n_size_w) - W'(n_shrink_w);
        w_hb   = f_ext(n_top) + W'(n_size_h) - W'(n_shrink_h);
        w_hl_s = f_sat(w_hl);
        w_ht_s = f_sat(w_ht);
        w_hr_s = f_sat(w_hr);
        w_hb_s = f_sat(w_hb);
        n_out_data = {f_low(w_hb_s), f_low(w_hr_s), f_low(w_ht_s), f_low(w_hl_s),
                      n_frame, f_low(n_vy), f_low(n_vx), f_low(n_top), f_low(n_left)};
    end

    // State registers commit as the item moves into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left     <= '0;
            r_top      <= '0;
            r_vx       <= '0;
            r_vy       <= '0;
            r_size_w   <= '0;
            r_size_h   <= '0;
            r_shrink_w <= '0;
            r_shrink_h <= '0;
            r_frame    <= '0;
            r_delay    <= '0;
            r_dying    <= 1'b0;
        end else if (w_adv) begin
            r_left     <= n_left;
            r_top      <= n_top;
            r_vx       <= n_vx;
            r_vy       <= n_vy;
            r_size_w   <= n_size_w;
            r_size_h   <= n_size_h;
            r_shrink_w <= n_shrink_w;
            r_shrink_h <= n_shrink_h;
            r_frame    <= n_frame;
            r_delay    <= n_delay;
            r_dying    <= n_dying;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_killed <= n_killed;
            r_out_data   <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_killed;
    assign o_m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_place_not_killed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_kind == KIND_PLACE) |=> (!o_m_axis_tuser && r_frame == '0 && !r_dying))
        else $error("place transfer did not clear the sprite or reported kill");

    a_dying_tick_kills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_kind == KIND_TICK && r_dying) |=> o_m_axis_tuser)
        else $error("tick on a dying sprite did not report kill");

    a_kill_holds_motion: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && n_killed) |=> (r_left == $past(r_left) && r_top == $past(r_top) &&
                                 r_vx == $past(r_vx) && r_vy == $past(r_vy)))
        else $error("killed result moved the sprite");

    a_stall_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_adv) |=> (r_left == $past(r_left) && r_frame == $past(r_frame) &&
                      r_dying == $past(r_dying)))
        else $error("sprite state changed without a transfer into the result register");

    a_reset_empty: assert property (@(posedge i_clk)
        (!i_rst_n) |=> (!o_m_axis_tvalid && !r_in_valid))
        else $error("pipeline not empty after reset");
`endif

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for sprite_motion_bounds_update: directed and random item streams.
// An in-bench predictor of the sprite state gives the expected results.
// Depends on smbu_pkg and the sprite_motion_bounds_update RTL.
`timescale 1ns / 1ps

module testbench;
    import smbu_pkg::*;

    localparam int     CLK_PERIOD     = 10;
    localparam int     CYCLE_LIMIT    = 1000000;
    localparam int     RESULT_LATENCY = 2;
    localparam longint SHRINK         = 12;
    localparam longint COORD_MAX      = 32767;
    localparam longint COORD_MIN      = -32768;
    localparam int     RANDOM_PHASES  = 10;
    localparam int     PHASE_ITEMS    = 123;

    // One result as it appears on the result stream.
    typedef struct packed {
        logic        killed;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] vel_x;
        logic [15:0] vel_y;
        logic [7:0]  frame_index;
        logic [15:0] hit_left;
        logic [15:0] hit_top;
        logic [15:0] hit_right;
        logic [15:0] hit_bottom;
    } sprite_result_t;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_s_axis_tvalid;
    logic                      o_s_axis_tready;
    // tdata: place_x, place_y, sprite_width, sprite_height, place_vx, place_vy
    logic [IN_TDATA_BITS-1:0]  i_s_axis_tdata;
    // tuser: kind
    logic [KIND_BITS-1:0]      i_s_axis_tuser;
    logic                      o_m_axis_tvalid;
    logic                      i_m_axis_tready;
    // tdata: pos_x, pos_y, vel_x, vel_y, frame_index,
    //        hit_left, hit_top, hit_right, hit_bottom
    logic [OUT_TDATA_BITS-1:0] o_m_axis_tdata;
    // tuser: killed
    logic                      o_m_axis_tuser;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]   i_cfg_index;
    logic [FIELD_BITS-1:0]     i_cfg_data;

    sprite_result_t expected_results[$];
    int             error_count = 0;
    bit             in_gaps     = 1'b0;
    bit             out_stalls  = 1'b0;

    // Predicted registers.
    longint               bnd_left     = 0;
    longint               bnd_top      = 0;
    longint               bnd_right    = longint'(BOUND_RIGHT_RST);
    longint               bnd_bottom   = longint'(BOUND_BOTTOM_RST);
    logic [EDGE_BITS-1:0] rule         = EDGE_STOP;
    longint               frames       = longint'(FRAME_COUNT_RST);
    longint               delay_reload = 0;
    bit                   single_pass  = 1'b0;

    // Predicted sprite state.
    longint spr_x = 0, spr_y = 0, spr_w = 0, spr_h = 0;
    longint spr_vx = 0, spr_vy = 0, spr_frame = 0, spr_delay = 0;
    bit     spr_dying = 1'b0;

    sprite_motion_bounds_update dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Run limit: a hung handshake ends the run as a failure.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Coordinate saturation to the signed 16-bit range.
    function automatic longint clamp_coord(longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    // Current sprite state with its collision rectangle.
    function automatic sprite_result_t sprite_snapshot(bit killed);
        longint         sx, sy;
        sprite_result_t r;
        sx = spr_w / SHRINK;
        sy = spr_h / SHRINK;
        r.killed      = killed;
        r.pos_x       = 16'(spr_x);
        r.pos_y       = 16'(spr_y);
        r.vel_x       = 16'(spr_vx);
        r.vel_y       = 16'(spr_vy);
        r.frame_index = 8'(spr_frame);
        r.hit_left    = 16'(clamp_coord(spr_x + sx));
        r.hit_top     = 16'(clamp_coord(spr_y + sy));
        r.hit_right   = 16'(clamp_coord(spr_x + spr_w - sx));
        r.hit_bottom  = 16'(clamp_coord(spr_y + spr_h - sy));
        return r;
    endfunction

    // Animation step: the delay counter gates the frame advance.
    function automatic void advance_frame();
        if (delay_reload < 0) return;
        spr_delay = spr_delay - 1;
        if (spr_delay > 0) return;
        spr_delay = delay_reload;
        spr_frame = spr_frame + 1;
        if (spr_frame >= frames) begin
            if (single_pass) begin
                spr_dying = 1'b1;
                if (spr_frame > 255) spr_frame = 255;
            end else begin
                spr_frame = 0;
            end
        end
    endfunction

    // Expected result of one accepted item; updates the predicted state.
    function automatic sprite_result_t predict_motion(logic [KIND_BITS-1:0] kind,
                                                      logic [IN_TDATA_BITS-1:0] data);
        longint nx, ny, nvx, nvy;
        if (kind == KIND_PLACE) begin
            spr_x     = longint'($signed(data[15:0]));
            spr_y     = longint'($signed(data[31:16]));
            spr_w     = longint'(data[43:32]);
            spr_h     = longint'(data[55:44]);
            spr_vx    = longint'($signed(data[71:56]));
            spr_vy    = longint'($signed(data[87:72]));
            spr_frame = 0;
            spr_delay = 0;
            spr_dying = 1'b0;
            return sprite_snapshot(1'b0);
        end
        if (kind == KIND_KILL) begin
            spr_dying = 1'b1;
            return sprite_snapshot(1'b0);
        end
        if (kind == KIND_UNUSED) return sprite_snapshot(1'b0);
        if (spr_dying) return sprite_snapshot(1'b1);

        advance_frame();
        nx  = spr_x + spr_vx;
        ny  = spr_y + spr_vy;
        nvx = spr_vx;
        nvy = spr_vy;
        case (rule)
            EDGE_WRAP: begin
                if (nx + spr_w < bnd_left) nx = bnd_right;
                else if (nx > bnd_right) nx = bnd_left - spr_w;
                if (ny + spr_h < bnd_top) ny = bnd_bottom;
                else if (ny > bnd_bottom) ny = bnd_top - spr_h;
            end
            EDGE_BOUNCE: begin
                if (nx < bnd_left) begin
                    nx  = bnd_left;
                    nvx = -nvx;
                end else if (nx + spr_w > bnd_right) begin
                    nx  = bnd_right - spr_w;
                    nvx = -nvx;
                end
                if (ny < bnd_top) begin
                    ny  = bnd_top;
                    nvy = -nvy;
                end else if (ny + spr_h > bnd_bottom) begin
                    ny  = bnd_bottom - spr_h;
                    nvy = -nvy;
                end
            end
            EDGE_DIE: begin
                // Leaving the area reports kill without moving.
                if (nx + spr_w < bnd_left || nx > bnd_right ||
                    ny + spr_h < bnd_top || ny > bnd_bottom)
                    return sprite_snapshot(1'b1);
            end
            default: begin
                // Stop rule: clamp to the area and halt; the left and top bounds win.
                if (nx < bnd_left || nx > bnd_right - spr_w) begin
                    if (nx > bnd_right - spr_w) nx = bnd_right - spr_w;
                    if (nx < bnd_left) nx = bnd_left;
                    nvx = 0;
                    nvy = 0;
                end
                if (ny < bnd_top || ny > bnd_bottom - spr_h) begin
                    if (ny > bnd_bottom - spr_h) ny = bnd_bottom - spr_h;
                    if (ny < bnd_top) ny = bnd_top;
                    nvx = 0;
                    nvy = 0;
                end
            end
        endcase
        spr_vx = clamp_coord(nvx);
        spr_vy = clamp_coord(nvy);
        spr_x  = clamp_coord(nx);
        spr_y  = clamp_coord(ny);
        return sprite_snapshot(1'b0);
    endfunction

    // Register write as seen by the predictor.
    function automatic void apply_register(logic [CFG_IDX_BITS-1:0] idx,
                                           logic [FIELD_BITS-1:0] val);
        case (idx)
            CFG_BOUND_LEFT:   bnd_left     = longint'($signed(val));
            CFG_BOUND_TOP:    bnd_top      = longint'($signed(val));
            CFG_BOUND_RIGHT:  bnd_right    = longint'($signed(val));
            CFG_BOUND_BOTTOM: bnd_bottom   = longint'($signed(val));
            CFG_EDGE_MODE:    rule         = val[EDGE_BITS-1:0];
            CFG_FRAME_COUNT:  frames       = longint'(val[FRAME_BITS-1:0]);
            CFG_FRAME_DELAY:  delay_reload = longint'($signed(val));
            default:          single_pass  = val[0];
        endcase
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            error_count++;
        end
    endtask

    // Monitor: results are checked first, then new transfers are predicted.
    always @(posedge i_clk) begin
        sprite_result_t want;
        sprite_result_t got;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = {o_m_axis_tuser, o_m_axis_tdata[15:0], o_m_axis_tdata[31:16],
                       o_m_axis_tdata[47:32], o_m_axis_tdata[63:48], o_m_axis_tdata[71:64],
                       o_m_axis_tdata[87:72], o_m_axis_tdata[103:88],
                       o_m_axis_tdata[119:104], o_m_axis_tdata[135:120]};
                if (expected_results.size() == 0) begin
                    $error("result transfer with no expected result waiting");
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("killed", 16'(want.killed), 16'(got.killed));
                    check_field("pos_x", want.pos_x, got.pos_x);
                    check_field("pos_y", want.pos_y, got.pos_y);
                    check_field("vel_x", want.vel_x, got.vel_x);
                    check_field("vel_y", want.vel_y, got.vel_y);
                    check_field("frame_index", 16'(want.frame_index), 16'(got.frame_index));
                    check_field("hit_left", want.hit_left, got.hit_left);
                    check_field("hit_top", want.hit_top, got.hit_top);
                    check_field("hit_right", want.hit_right, got.hit_right);
                    check_field("hit_bottom", want.hit_bottom, got.hit_bottom);
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready)
                expected_results.push_back(predict_motion(i_s_axis_tuser, i_s_axis_tdata));
            if (i_cfg_valid && o_cfg_ready)
                apply_register(i_cfg_index, i_cfg_data);
        end
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side back-pressure.
    initial begin : result_sink
        int n;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (out_stalls && $urandom_range(0, 99) < 30) begin
                n = idle_cycles();
                i_m_axis_tready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic logic [IN_TDATA_BITS-1:0] place_data(longint x, longint y,
                                                            longint w, longint h,
                                                            longint vx, longint vy);
        return {16'(vy), 16'(vx), 12'(h), 12'(w), 16'(y), 16'(x)};
    endfunction

    function automatic logic [IN_TDATA_BITS-1:0] noise_data();
        return IN_TDATA_BITS'({$urandom(), $urandom(), $urandom()});
    endfunction

    function automatic longint small_signed(int lim);
        return longint'($urandom_range(0, 2 * lim)) - longint'(lim);
    endfunction

    // Sends one item; returns at the edge of its transfer, or after the gap that follows.
    task automatic send_item(logic [KIND_BITS-1:0] kind, logic [IN_TDATA_BITS-1:0] data);
        int gap;
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= kind;
        i_s_axis_tdata  <= data;
        do @(posedge i_clk); while (!o_s_axis_tready);
        gap = in_gaps ? idle_cycles() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Drains the block: no item offered, every expected result in, pipeline settled.
    task automatic wait_idle();
        if (i_s_axis_tvalid) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
        end
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (RESULT_LATENCY + 2) @(posedge i_clk);
    endtask

    // One register write; the block must be idle.
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, longint value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= 16'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Reset settings, stop rule: field extremes, saturated edges, narrow area.
    task automatic test_place_extremes();
        send_item(KIND_PLACE, place_data(100, 50, 48, 36, 5, -3));
        send_item(KIND_TICK, noise_data());
        send_item(KIND_PLACE, place_data(COORD_MIN, COORD_MIN, 4095, 4095, COORD_MIN, COORD_MIN));
        send_item(KIND_TICK, noise_data());
        send_item(KIND_PLACE, place_data(COORD_MAX, COORD_MAX, 4095, 4095, COORD_MAX, COORD_MAX));
        send_item(KIND_TICK, '0);
    endtask

    // Kill marks the sprite, the next tick reports it, unused kinds change nothing.
    task automatic test_kill_and_unused();
        send_item(KIND_KILL, noise_data());
        send_item(KIND_TICK, noise_data());
        send_item(KIND_UNUSED, noise_data());
        send_item(KIND_PLACE, place_data(10, 10, 12, 12, 1, 1));
        send_item(KIND_TICK, '1);
    endtask

    // Wrap, bounce with a saturating flip, and die leaving the area.
    task automatic test_edge_rules();
        wait_idle();
        write_reg(CFG_EDGE_MODE, longint'(EDGE_WRAP));
        send_item(KIND_PLACE, place_data(630, 470, 20, 20, 15, 15));
        send_item(KIND_TICK, noise_data());
        wait_idle();
        write_reg(CFG_EDGE_MODE, longint'(EDGE_BOUNCE));
        send_item(KIND_PLACE, place_data(0, 0, 16, 16, COORD_MIN, 5));
        send_item(KIND_TICK, noise_data());
        wait_idle();
        write_reg(CFG_EDGE_MODE, longint'(EDGE_DIE));
        send_item(KIND_PLACE, place_data(630, 10, 20, 20, 30, 0));
        send_item(KIND_TICK, noise_data());
    endtask

    // Frame delay, wraparound, one-shot with a zero frame count, animation disabled.
    task automatic test_animation();
        wait_idle();
        write_reg(CFG_EDGE_MODE, longint'(EDGE_STOP));
        write_reg(CFG_FRAME_COUNT, 3);
        write_reg(CFG_FRAME_DELAY, 1);
        write_reg(CFG_ONE_SHOT, 0);
        send_item(KIND_PLACE, place_data(0, 0, 8, 8, 0, 0));
        repeat (3) send_item(KIND_TICK, noise_data());
        wait_idle();
        write_reg(CFG_FRAME_COUNT, 0);
        write_reg(CFG_FRAME_DELAY, 0);
        write_reg(CFG_ONE_SHOT, 1);
        send_item(KIND_PLACE, place_data(5, 5, 8, 8, 1, 0));
        repeat (2) send_item(KIND_TICK, noise_data());
        wait_idle();
        write_reg(CFG_FRAME_DELAY, -1);
        send_item(KIND_PLACE, place_data(5, 5, 8, 8, 1, 0));
        send_item(KIND_TICK, noise_data());
    endtask

    // Random register set, with ordinary areas, full-range areas and the extremes.
    task automatic randomise_config();
        longint l, t, r, b;
        int     pick;
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            l = small_signed(300);
            t = small_signed(300);
            r = l + longint'($urandom_range(0, 900));
            b = t + longint'($urandom_range(0, 900));
        end else if (pick < 9) begin
            l = longint'($signed(16'($urandom())));
            t = longint'($signed(16'($urandom())));
            r = longint'($signed(16'($urandom())));
            b = longint'($signed(16'($urandom())));
        end else begin
            l = COORD_MIN;
            t = COORD_MIN;
            r = COORD_MAX;
            b = COORD_MAX;
        end
        write_reg(CFG_BOUND_LEFT, l);
        write_reg(CFG_BOUND_TOP, t);
        write_reg(CFG_BOUND_RIGHT, r);
        write_reg(CFG_BOUND_BOTTOM, b);
        write_reg(CFG_EDGE_MODE, longint'($urandom_range(0, 3)));
        pick = $urandom_range(0, 9);
        if (pick < 6) write_reg(CFG_FRAME_COUNT, longint'($urandom_range(1, 8)));
        else if (pick < 8) write_reg(CFG_FRAME_COUNT, 255);
        else write_reg(CFG_FRAME_COUNT, longint'($urandom_range(1, 255)));
        pick = $urandom_range(0, 9);
        if (pick < 2) write_reg(CFG_FRAME_DELAY, -1);
        else if (pick < 7) write_reg(CFG_FRAME_DELAY, longint'($urandom_range(0, 5)));
        else if (pick < 8) write_reg(CFG_FRAME_DELAY, 32767);
        else write_reg(CFG_FRAME_DELAY, longint'($urandom_range(0, 32767)));
        write_reg(CFG_ONE_SHOT, longint'($urandom_range(0, 1)));
    endtask

    // Mostly well-formed motion inside the area, with noise, kills and unused kinds.
    task automatic run_motion_phase(int n_items);
        int     sent, r;
        longint span_x, span_y, x, y, w, h, vx, vy;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                span_x = bnd_right - bnd_left;
                span_y = bnd_bottom - bnd_top;
                if (span_x < 0) span_x = 0;
                if (span_y < 0) span_y = 0;
                x = bnd_left + longint'($urandom_range(0, 32'(span_x)));
                y = bnd_top + longint'($urandom_range(0, 32'(span_y)));
                w = ($urandom_range(0, 9) < 8) ? longint'($urandom_range(0, 120))
                                                : longint'($urandom_range(0, 4095));
                h = ($urandom_range(0, 9) < 8) ? longint'($urandom_range(0, 120))
                                                : longint'($urandom_range(0, 4095));
                vx = ($urandom_range(0, 9) < 8) ? small_signed(16)
                                                 : longint'($signed(16'($urandom())));
                vy = ($urandom_range(0, 9) < 8) ? small_signed(16)
                                                 : longint'($signed(16'($urandom())));
                send_item(KIND_PLACE, place_data(x, y, w, h, vx, vy));
                sent++;
            end else if (r < 8) begin
                send_item(KIND_PLACE, noise_data());
                sent++;
            end else if (r < 11) begin
                send_item(KIND_KILL, noise_data());
                sent++;
            end else if (r < 13) begin
                send_item(KIND_UNUSED, noise_data());
            end else begin
                send_item(KIND_TICK, noise_data());
                sent++;
            end
        end
    endtask

    // Random phases; each starts from a drained block with a fresh register set.
    task automatic test_random_motion();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_idle();
            randomise_config();
            in_gaps    = (phase % 3 != 0);
            out_stalls = (phase % 3 != 0);
            run_motion_phase(PHASE_ITEMS);
        end
    endtask

    // Main sequence.
    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = KIND_TICK;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_BOUND_LEFT;
        i_cfg_data      = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_place_extremes();
        in_gaps    = 1'b1;
        out_stalls = 1'b1;
        test_kill_and_unused();
        test_edge_rules();
        test_animation();
        test_random_motion();
        wait_idle();

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sprite_motion_bounds_update.f =====
sv/smbu_pkg.sv
sv/smbu_shrink_div.sv
sv/sprite_motion_bounds_update.sv
sim/testbench.sv
